/* hw/rtl/tgad_pkg.sv */
// Shared types and constants for the TGA true-color stream decoder.
package tgad_pkg;

  // Header layout
  localparam int unsigned HDR_BYTES  = 18;
  localparam logic [4:0]  HDR_LAST   = 5'd17;
  localparam logic [7:0]  TRUECOLOR_TYPE = 8'd2;
  localparam logic [7:0]  PIXEL_BITS = 8'd24;

  // Descriptor byte fields
  localparam logic [7:0] ATTR_MASK       = 8'h0F;
  localparam logic [7:0] RTL_MASK        = 8'h10;
  localparam logic [7:0] TOP_MASK        = 8'h20;
  localparam logic [7:0] INTERLEAVE_MASK = 8'hC0;

  // Raster limit register
  localparam int unsigned LIMIT_W     = 34;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 34'd67108864;

  // Error codes
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_COLORMAPPED = 4'd1;
  localparam logic [3:0] ERR_MAPSPEC     = 4'd2;
  localparam logic [3:0] ERR_TYPE        = 4'd3;
  localparam logic [3:0] ERR_ORIGIN      = 4'd4;
  localparam logic [3:0] ERR_ZERO_DIM    = 4'd5;
  localparam logic [3:0] ERR_TOO_LARGE   = 4'd6;
  localparam logic [3:0] ERR_BPP         = 4'd7;
  localparam logic [3:0] ERR_ATTR        = 4'd8;
  localparam logic [3:0] ERR_RTL         = 4'd9;
  localparam logic [3:0] ERR_INTERLEAVE  = 4'd10;
  localparam logic [3:0] ERR_TRUNCATED   = 4'd11;
  localparam logic [3:0] ERR_TRAILING    = 4'd12;

  // One result item
  typedef struct packed {
    logic        is_error;
    logic [3:0]  error_code;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        image_done;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } tgad_result_t;

endpackage

/* hw/rtl/tga_truecolor_stream_decoder_core.sv */
// Top level of the TGA true-color stream decoder: header check, ID skip, BGR to RGB pixels.
// Each result is registered into the output stage: out_q, or skid_q while the output stalls.
// Throughput: one byte per cycle while the skid is empty; per-byte work is counters and small compares.
// A two-entry output stage (register plus skid) keeps input requests flowing while a
// result waits; the header product w*h is registered and reused for the size check.
// Reset (rst, synchronous): waits for a new header, limit register set to 67108864.
module tga_truecolor_stream_decoder_core (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tgad_pkg::LIMIT_W-1:0]  cfg_data,
  // byte input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          last_byte,
  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_error,
  output logic [3:0]                    error_code,
  output logic [15:0]                   pixel_x,
  output logic [15:0]                   pixel_y,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue,
  output logic                          image_done,
  output logic [15:0]                   image_width,
  output logic [15:0]                   image_height
);
  import tgad_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_ID     = 3'd1,
    PH_RASTER = 3'd2,
    PH_END    = 3'd3,
    PH_DRAIN  = 3'd4
  } phase_t;

  // Control state
  phase_t              parse_phase, parse_phase_next;
  logic [4:0]          header_count, header_count_next;
  logic [7:0]          id_remaining, id_remaining_next;
  logic [15:0]         width_reg, width_reg_next;
  logic [15:0]         height_reg, height_reg_next;
  logic                top_first, top_first_next;
  logic [15:0]         column_count, column_count_next;
  logic [15:0]         row_count, row_count_next;
  logic [1:0]          byte_in_pixel, byte_in_pixel_next;
  logic [LIMIT_W-1:0]  max_raster_bytes;

  // Payload state
  logic [7:0]          header_store [0:HDR_BYTES-2];
  logic [7:0]          held_blue;
  logic [7:0]          held_green;
  logic [31:0]         area;

  // Output stage
  logic                skid_valid;
  tgad_result_t        out_q, skid_q, res;
  logic                res_valid;

  logic                accept;
  logic [15:0]         hdr_w, hdr_h;
  logic [LIMIT_W-1:0]  raster_size;
  logic [3:0]          hdr_code;
  logic [15:0]         col_inc, row_inc, flip_y;
  logic                row_wrap, frame_done;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign accept    = in_valid && in_ready;

  // Header fields from the stored bytes; the descriptor is the current byte
  assign hdr_w = {header_store[13], header_store[12]};
  assign hdr_h = {header_store[15], header_store[14]};
  assign raster_size = {1'b0, area, 1'b0} + {2'b00, area};

  always_comb begin
    if (header_store[1] != 8'd0) begin
      hdr_code = ERR_COLORMAPPED;
    end else if ((header_store[3] | header_store[4] | header_store[5] |
                  header_store[6] | header_store[7]) != 8'd0) begin
      hdr_code = ERR_MAPSPEC;
    end else if (header_store[2] != TRUECOLOR_TYPE) begin
      hdr_code = ERR_TYPE;
    end else if ((header_store[8] | header_store[9] | header_store[10] |
                  header_store[11]) != 8'd0) begin
      hdr_code = ERR_ORIGIN;
    end else if (hdr_w == 16'd0 || hdr_h == 16'd0) begin
      hdr_code = ERR_ZERO_DIM;
    end else if (raster_size > max_raster_bytes) begin
      hdr_code = ERR_TOO_LARGE;
    end else if (header_store[16] != PIXEL_BITS) begin
      hdr_code = ERR_BPP;
    end else if ((data_byte & ATTR_MASK) != 8'd0) begin
      hdr_code = ERR_ATTR;
    end else if ((data_byte & RTL_MASK) != 8'd0) begin
      hdr_code = ERR_RTL;
    end else if ((data_byte & INTERLEAVE_MASK) != 8'd0) begin
      hdr_code = ERR_INTERLEAVE;
    end else begin
      hdr_code = ERR_NONE;
    end
  end

  // Pixel position arithmetic
  assign col_inc    = column_count + 16'd1;
  assign row_inc    = row_count + 16'd1;
  assign row_wrap   = (col_inc == width_reg);
  assign frame_done = row_wrap && (row_inc == height_reg);
  assign flip_y     = height_reg - 16'd1 - row_count;

  // Next state and result for the byte on the input
  always_comb begin
    parse_phase_next   = parse_phase;
    header_count_next  = header_count;
    id_remaining_next  = id_remaining;
    width_reg_next     = width_reg;
    height_reg_next    = height_reg;
    top_first_next     = top_first;
    column_count_next  = column_count;
    row_count_next     = row_count;
    byte_in_pixel_next = byte_in_pixel;
    res_valid          = 1'b0;
    res                = '0;
    res.is_error       = 1'b1;

    unique case (parse_phase)
      PH_HEADER: begin
        if (header_count != HDR_LAST) begin
          header_count_next = header_count + 5'd1;
          if (last_byte) begin
            res_valid        = 1'b1;
            res.error_code   = ERR_TRUNCATED;
            header_count_next = '0;
          end
        end else begin
          header_count_next = '0;
          if (hdr_code != ERR_NONE) begin
            res_valid      = 1'b1;
            res.error_code = hdr_code;
            if (!last_byte) parse_phase_next = PH_DRAIN;
          end else begin
            width_reg_next  = hdr_w;
            height_reg_next = hdr_h;
            top_first_next  = (data_byte & TOP_MASK) != 8'd0;
            if (last_byte) begin
              res_valid      = 1'b1;
              res.error_code = ERR_TRUNCATED;
            end else begin
              id_remaining_next  = header_store[0];
              column_count_next  = '0;
              row_count_next     = '0;
              byte_in_pixel_next = '0;
              parse_phase_next   = (header_store[0] != 8'd0) ? PH_ID : PH_RASTER;
            end
          end
        end
      end
      PH_ID: begin
        if (last_byte) begin
          res_valid      = 1'b1;
          res.error_code = ERR_TRUNCATED;
        end else begin
          id_remaining_next = id_remaining - 8'd1;
          if (id_remaining == 8'd1) parse_phase_next = PH_RASTER;
        end
      end
      PH_RASTER: begin
        if (byte_in_pixel != 2'd2) begin
          byte_in_pixel_next = byte_in_pixel + 2'd1;
          if (last_byte) begin
            res_valid      = 1'b1;
            res.error_code = ERR_TRUNCATED;
          end
        end else if (last_byte && !frame_done) begin
          res_valid      = 1'b1;
          res.error_code = ERR_TRUNCATED;
        end else begin
          byte_in_pixel_next = '0;
          column_count_next  = row_wrap ? 16'd0 : col_inc;
          row_count_next     = row_wrap ? row_inc : row_count;
          res_valid          = 1'b1;
          res.is_error       = 1'b0;
          res.error_code     = ERR_NONE;
          res.pixel_x        = column_count;
          res.pixel_y        = top_first ? row_count : flip_y;
          res.red            = data_byte;
          res.green          = held_green;
          res.blue           = held_blue;
          res.image_done     = frame_done && last_byte;
          res.image_width    = width_reg;
          res.image_height   = height_reg;
          if (frame_done && !last_byte) parse_phase_next = PH_END;
        end
      end
      PH_END: begin
        res_valid      = 1'b1;
        res.error_code = ERR_TRAILING;
        if (!last_byte) parse_phase_next = PH_DRAIN;
      end
      default: begin
        // drain and unused codes: wait for the last byte
      end
    endcase

    // Return to header phase at the end of every stream
    if (last_byte) begin
      parse_phase_next   = PH_HEADER;
      header_count_next  = '0;
      id_remaining_next  = '0;
      column_count_next  = '0;
      row_count_next     = '0;
      byte_in_pixel_next = '0;
    end
  end

  // Hold control state, limit register and output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_HEADER;
      header_count     <= '0;
      id_remaining     <= '0;
      width_reg        <= '0;
      height_reg       <= '0;
      top_first        <= 1'b0;
      column_count     <= '0;
      row_count        <= '0;
      byte_in_pixel    <= '0;
      max_raster_bytes <= LIMIT_RESET;
      out_valid        <= 1'b0;
      skid_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) max_raster_bytes <= cfg_data;
      if (accept) begin
        parse_phase   <= parse_phase_next;
        header_count  <= header_count_next;
        id_remaining  <= id_remaining_next;
        width_reg     <= width_reg_next;
        height_reg    <= height_reg_next;
        top_first     <= top_first_next;
        column_count  <= column_count_next;
        row_count     <= row_count_next;
        byte_in_pixel <= byte_in_pixel_next;
      end
      // load a new request, or advance the skid when a request leaves
      if (accept && res_valid) begin
        if (!out_valid || out_ready) out_valid  <= 1'b1;
        else                         skid_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  // Payload registers: header bytes, held channels, area product, result data
  always_ff @(posedge clk) begin
    area <= {16'd0, hdr_w} * {16'd0, hdr_h};
    if (accept && parse_phase == PH_HEADER && header_count != HDR_LAST) begin
      header_store[header_count] <= data_byte;
    end
    if (accept && parse_phase == PH_RASTER) begin
      if (byte_in_pixel == 2'd0) held_blue  <= data_byte;
      if (byte_in_pixel == 2'd1) held_green <= data_byte;
    end
    if (accept && res_valid) begin
      if (!out_valid || out_ready) out_q  <= res;
      else                         skid_q <= res;
    end else if (out_valid && out_ready) begin
      out_q <= skid_q;
    end
  end

  assign is_error     = out_q.is_error;
  assign error_code   = out_q.error_code;
  assign pixel_x      = out_q.pixel_x;
  assign pixel_y      = out_q.pixel_y;
  assign red          = out_q.red;
  assign green        = out_q.green;
  assign blue         = out_q.blue;
  assign image_done   = out_q.image_done;
  assign image_width  = out_q.image_width;
  assign image_height = out_q.image_height;

endmodule

/* hw/rtl/tgad_checker.sv */
// Port-level checker for the TGA decoder, bound to the top level.
module tgad_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        is_error,
  input logic [3:0]  error_code,
  input logic [15:0] pixel_x,
  input logic [15:0] pixel_y,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic        image_done,
  input logic [15:0] image_width,
  input logic [15:0] image_height
);
  import tgad_pkg::*;

  // Hold a stalled result request
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(error_code) && $stable(pixel_x)
      && $stable(pixel_y) && $stable(red))
    else $error("stalled result changed");

  // Error results carry a code and nothing else
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_error |-> error_code != ERR_NONE && pixel_x == 16'd0
      && pixel_y == 16'd0 && red == 8'd0 && green == 8'd0 && blue == 8'd0
      && !image_done && image_width == 16'd0 && image_height == 16'd0)
    else $error("error result carries pixel data");

  // Pixels land inside the image
  a_pix_bounds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_error |-> error_code == ERR_NONE && pixel_x < image_width
      && pixel_y < image_height)
    else $error("pixel outside image");

  // The final pixel is in the last column of the image; its row is not checked here
  a_done_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_done |-> !is_error && pixel_x == image_width - 16'd1)
    else $error("image_done on a pixel that is not the last column");

endmodule

bind tga_truecolor_stream_decoder_core tgad_checker u_tgad_checker (.*);

/* dv/tb_tga_truecolor_stream_decoder_core.sv */
// Self-checking testbench for the TGA true-color stream decoder core.
`timescale 1ns / 1ps

module tb_tga_truecolor_stream_decoder_core;
  import tgad_pkg::*;

  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 34'd12884508675;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned BYTE_BUDGET = 1250;
  localparam int unsigned CFG_STEP = 40;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_ID,
    PH_RASTER,
    PH_END,
    PH_DRAIN
  } parse_phase_e;

  // Mirror of the decoder: header check, ID skip, BGR to RGB pixels, stream errors
  class tga_decode_scoreboard;
    logic [LIMIT_W-1:0] raster_limit;
    logic [7:0]   hdr [HDR_BYTES];
    parse_phase_e phase;
    int unsigned  hdr_count;
    logic [7:0]   id_left;
    logic [15:0]  width;
    logic [15:0]  height;
    logic [15:0]  col;
    logic [15:0]  row;
    bit           top_first;
    logic [1:0]   lane;
    logic [7:0]   held_blue;
    logic [7:0]   held_green;
    tgad_result_t upcoming[$];
    int unsigned  errors;

    function new();
      errors = 0;
      raster_limit = LIMIT_RESET;
      foreach (hdr[i]) hdr[i] = 8'h00;
      width = '0;
      height = '0;
      top_first = 1'b0;
      restart();
    endfunction

    // Return to waiting for a new header
    function void restart();
      phase = PH_HEADER;
      hdr_count = 0;
      id_left = '0;
      col = '0;
      row = '0;
      lane = '0;
      held_blue = '0;
      held_green = '0;
    endfunction

    // First failing header check in the decoder's check order; latch geometry on success
    function logic [3:0] header_fault();
      logic [63:0] w;
      logic [63:0] h;
      logic [7:0]  d;
      d = hdr[17];
      w = {48'd0, hdr[13], hdr[12]};
      h = {48'd0, hdr[15], hdr[14]};
      if (hdr[1] != 8'h00) return ERR_COLORMAPPED;
      if ({hdr[3], hdr[4], hdr[5], hdr[6], hdr[7]} != 40'd0) return ERR_MAPSPEC;
      if (hdr[2] != TRUECOLOR_TYPE) return ERR_TYPE;
      if ({hdr[8], hdr[9], hdr[10], hdr[11]} != 32'd0) return ERR_ORIGIN;
      if (w == 64'd0 || h == 64'd0) return ERR_ZERO_DIM;
      if (w * h * 64'd3 > {30'd0, raster_limit}) return ERR_TOO_LARGE;
      if (hdr[16] != PIXEL_BITS) return ERR_BPP;
      if ((d & ATTR_MASK) != 8'h00) return ERR_ATTR;
      if ((d & RTL_MASK) != 8'h00) return ERR_RTL;
      if ((d & INTERLEAVE_MASK) != 8'h00) return ERR_INTERLEAVE;
      width = w[15:0];
      height = h[15:0];
      top_first = (d & TOP_MASK) != 8'h00;
      return ERR_NONE;
    endfunction

    function void push_fault(logic [3:0] code, bit last);
      tgad_result_t r;
      r = '0;
      r.is_error = 1'b1;
      r.error_code = code;
      upcoming.push_back(r);
      if (last) restart();
      else phase = PH_DRAIN;
    endfunction

    // Note one accepted byte request and queue the result it causes
    function void take_byte(logic [7:0] b, bit last);
      tgad_result_t r;
      logic [3:0]   code;
      bit           done;
      case (phase)
        PH_HEADER: begin
          hdr[hdr_count] = b;
          hdr_count++;
          if (hdr_count < HDR_BYTES) begin
            if (last) push_fault(ERR_TRUNCATED, 1'b1);
          end else begin
            hdr_count = 0;
            code = header_fault();
            if (code != ERR_NONE) begin
              push_fault(code, last);
            end else if (last) begin
              push_fault(ERR_TRUNCATED, 1'b1);
            end else begin
              id_left = hdr[0];
              col = '0;
              row = '0;
              lane = '0;
              phase = (id_left != 8'd0) ? PH_ID : PH_RASTER;
            end
          end
        end
        PH_ID: begin
          if (last) begin
            push_fault(ERR_TRUNCATED, 1'b1);
          end else begin
            id_left = id_left - 8'd1;
            if (id_left == 8'd0) phase = PH_RASTER;
          end
        end
        PH_RASTER: begin
          if (lane == 2'd0) begin
            held_blue = b;
            lane = 2'd1;
            if (last) push_fault(ERR_TRUNCATED, 1'b1);
          end else if (lane == 2'd1) begin
            held_green = b;
            lane = 2'd2;
            if (last) push_fault(ERR_TRUNCATED, 1'b1);
          end else begin
            lane = 2'd0;
            r = '0;
            r.pixel_x = col;
            r.pixel_y = top_first ? row : height - 16'd1 - row;
            col++;
            if (col >= width) begin
              col = '0;
              row++;
            end
            done = row >= height;
            if (last && !done) begin
              push_fault(ERR_TRUNCATED, 1'b1);
            end else begin
              r.red = b;
              r.green = held_green;
              r.blue = held_blue;
              r.image_done = done && last;
              r.image_width = width;
              r.image_height = height;
              upcoming.push_back(r);
              if (done) begin
                if (last) restart();
                else phase = PH_END;
              end
            end
          end
        end
        PH_END: push_fault(ERR_TRAILING, last);
        default: begin
          if (last) restart();
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Check one accepted result against the oldest prediction
    function void check_result(tgad_result_t got);
      tgad_result_t want;
      if (upcoming.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: is_error %0h code %0h x %0h y %0h",
                 $time, got.is_error, got.error_code, got.pixel_x, got.pixel_y);
        return;
      end
      want = upcoming.pop_front();
      compare_field("is_error", want.is_error, got.is_error);
      compare_field("error_code", want.error_code, got.error_code);
      compare_field("pixel_x", want.pixel_x, got.pixel_x);
      compare_field("pixel_y", want.pixel_y, got.pixel_y);
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("image_done", want.image_done, got.image_done);
      compare_field("image_width", want.image_width, got.image_width);
      compare_field("image_height", want.image_height, got.image_height);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         data_byte;
  logic               last_byte;
  logic               out_valid;
  logic               out_ready;
  logic               is_error;
  logic [3:0]         error_code;
  logic [15:0]        pixel_x;
  logic [15:0]        pixel_y;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic               image_done;
  logic [15:0]        image_width;
  logic [15:0]        image_height;
  tgad_result_t       seen;

  tga_decode_scoreboard decode_sb;
  logic [7:0]  stream_q[$];
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;
  bit          hold_req = 1'b0;

  assign seen = {is_error, error_code, pixel_x, pixel_y, red, green, blue,
                 image_done, image_width, image_height};

  tga_truecolor_stream_decoder_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_error     (is_error),
    .error_code   (error_code),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .image_done   (image_done),
    .image_width  (image_width),
    .image_height (image_height)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Check every accepted result; stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && out_valid && out_ready) decode_sb.check_result(seen);
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Drive out_ready in segments of differing stall density; hold off on request
  initial begin : result_stalls
    int unsigned seg;
    int unsigned mode;
    int unsigned i;
    out_ready = 1'b0;
    forever begin
      seg = $urandom_range(10, 80);
      mode = $urandom_range(0, 3);
      for (i = 0; i < seg; i++) begin
        @(negedge clk);
        if (hold_req) begin
          out_ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = $urandom_range(0, 3) != 0;
          2: out_ready = $urandom_range(0, 3) == 0;
          default: out_ready = (i % 6) < 3;
        endcase
      end
    end
  end

  // Offer one byte request; when a burst has run out, start a new one, often after idling
  task automatic offer_byte(input logic [7:0] b, input logic l);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    data_byte = b;
    last_byte = l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_sb.take_byte(b, l);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (decode_sb.upcoming.size() != 0) @(negedge clk);
  endtask

  // Send the built stream, flag on its final byte; optionally pause until drained
  task automatic send_stream(input int pause_at);
    int i;
    for (i = 0; i < stream_q.size(); i++) begin
      if (i == pause_at) drain_results();
      offer_byte(stream_q[i], i == stream_q.size() - 1);
    end
    in_valid = 1'b0;
  endtask

  // Write the raster limit once the decoder has gone idle
  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    decode_sb.raster_limit = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic void fill_header(input logic [7:0] id_len, input logic [15:0] w,
                                      input logic [15:0] h, input logic [7:0] desc);
    stream_q.delete();
    stream_q.push_back(id_len);
    stream_q.push_back(8'h00);
    stream_q.push_back(TRUECOLOR_TYPE);
    repeat (9) stream_q.push_back(8'h00);
    stream_q.push_back(w[7:0]);
    stream_q.push_back(w[15:8]);
    stream_q.push_back(h[7:0]);
    stream_q.push_back(h[15:8]);
    stream_q.push_back(PIXEL_BITS);
    stream_q.push_back(desc);
  endfunction

  // Break one header field so that the given check fails
  function automatic void corrupt_header(input logic [3:0] code);
    logic [7:0]  v;
    int unsigned k;
    v = 8'($urandom_range(1, 255));
    case (code)
      ERR_COLORMAPPED: stream_q[1] = v;
      ERR_MAPSPEC:     stream_q[$urandom_range(3, 7)] = v;
      ERR_TYPE:        stream_q[2] = (v == TRUECOLOR_TYPE) ? 8'h00 : v;
      ERR_ORIGIN:      stream_q[$urandom_range(8, 11)] = v;
      ERR_ZERO_DIM: begin
        k = $urandom_range(0, 2);
        if (k != 1) begin
          stream_q[12] = 8'h00;
          stream_q[13] = 8'h00;
        end
        if (k != 0) begin
          stream_q[14] = 8'h00;
          stream_q[15] = 8'h00;
        end
      end
      ERR_TOO_LARGE: begin
        stream_q[12] = 8'($urandom_range(0, 255));
        stream_q[13] = 8'($urandom_range(16, 255));
        stream_q[14] = 8'($urandom_range(0, 255));
        stream_q[15] = 8'($urandom_range(16, 255));
      end
      ERR_BPP:         stream_q[16] = (v == PIXEL_BITS) ? 8'h00 : v;
      ERR_ATTR:        stream_q[17] = stream_q[17] | 8'($urandom_range(1, 15));
      ERR_RTL:         stream_q[17] = stream_q[17] | RTL_MASK;
      ERR_INTERLEAVE:  stream_q[17] = stream_q[17] | {2'($urandom_range(1, 3)), 6'd0};
      default: ;
    endcase
  endfunction

  // Image stream with random ID and raster; keep cuts it short, extra adds trailing bytes
  task automatic run_image(input logic [7:0] id_len, input logic [15:0] w,
                           input logic [15:0] h, input logic [7:0] desc,
                           input longint unsigned keep, input int unsigned extra,
                           input int pause_at);
    longint unsigned total;
    longint unsigned n;
    total = 64'd18 + 64'(id_len) + 64'(w) * 64'(h) * 64'd3 + 64'(extra);
    n = (keep != 0 && keep < total) ? keep : total;
    fill_header(id_len, w, h, desc);
    while (stream_q.size() < n) stream_q.push_back(8'($urandom_range(0, 255)));
    while (stream_q.size() > n) void'(stream_q.pop_back());
    send_stream(pause_at);
  endtask

  // Small image with a broken header, sometimes a second fault, then tail bytes
  task automatic run_faulty(input logic [3:0] code, input int unsigned tail);
    fill_header(8'($urandom_range(0, 3)), 16'($urandom_range(1, 4)),
                16'($urandom_range(1, 4)), $urandom_range(0, 1) ? TOP_MASK : 8'h00);
    corrupt_header(code);
    if ($urandom_range(0, 3) == 0) corrupt_header(4'($urandom_range(code, ERR_INTERLEAVE)));
    repeat (tail) stream_q.push_back(8'($urandom_range(0, 255)));
    send_stream(-1);
  endtask

  initial begin : stimulus
    int unsigned     c;
    int unsigned     kind;
    int unsigned     cfg_sel;
    int unsigned     next_cfg;
    logic [7:0]      id_len;
    logic [15:0]     w;
    logic [15:0]     h;
    logic [7:0]      desc;
    longint unsigned total;
    logic [63:0]     span;
    logic [LIMIT_W-1:0] lim;

    decode_sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Clean images: both origins, shortest and longest ID field
    run_image(8'd0, 16'd1, 16'd1, 8'h00, 0, 0, -1);
    run_image(8'd2, 16'd3, 16'd2, TOP_MASK, 0, 0, -1);
    run_image(8'd255, 16'd2, 16'd2, 8'h00, 0, 0, -1);

    // Every header check, with drained tail bytes or failing on the flagged byte
    for (c = 1; c <= 10; c++) run_faulty(4'(c), c % 3);

    // Truncation: in the header, at its end, in the ID, in each pixel lane, on a pixel
    run_image(8'd0, 16'd2, 16'd2, 8'h00, 1, 0, -1);
    run_image(8'd0, 16'd2, 16'd2, 8'h00, 18, 0, -1);
    run_image(8'd4, 16'd2, 16'd2, 8'h00, 20, 0, -1);
    run_image(8'd0, 16'd2, 16'd2, TOP_MASK, 19, 0, -1);
    run_image(8'd0, 16'd2, 16'd2, TOP_MASK, 20, 0, -1);
    run_image(8'd0, 16'd2, 16'd2, 8'h00, 24, 0, -1);

    // Trailing bytes after a complete raster
    run_image(8'd0, 16'd1, 16'd1, 8'h00, 0, 1, -1);
    run_image(8'd1, 16'd2, 16'd1, TOP_MASK, 0, 3, -1);

    // Widest dimensions: rejected at the reset limit, accepted at the top limit
    run_image(8'd0, 16'hFFFF, 16'hFFFF, 8'h00, 27, 0, -1);
    write_limit(LIMIT_MAX);
    run_image(8'd0, 16'hFFFF, 16'hFFFF, 8'h00, 25, 0, -1);
    run_image(8'd0, 16'hFFFF, 16'hFFFF, TOP_MASK, 24, 0, -1);

    // Limit at its floor and exactly at a raster size
    write_limit(34'd3);
    run_image(8'd0, 16'd1, 16'd1, TOP_MASK, 0, 0, -1);
    run_image(8'd0, 16'd2, 16'd1, TOP_MASK, 0, 0, -1);
    write_limit(34'd18);
    run_image(8'd0, 16'd2, 16'd3, 8'h00, 0, 0, -1);
    write_limit(34'd17);
    run_image(8'd0, 16'd2, 16'd3, 8'h00, 0, 0, -1);
    write_limit(LIMIT_RESET);

    // Back-pressure: long receiver hold-off, then a sender pause mid-raster
    hold_req = 1'b1;
    run_image(8'd0, 16'd8, 16'd6, TOP_MASK, 0, 0, -1);
    run_image(8'd3, 16'd5, 16'd4, 8'h00, 0, 0, 30);

    // Random streams, mostly well formed, under a rotating raster limit
    next_cfg = bytes_sent;
    cfg_sel = 0;
    while (bytes_sent < BYTE_BUDGET) begin
      if (bytes_sent >= next_cfg) begin
        case (cfg_sel % 5)
          0: lim = 34'($urandom_range(3, 90));
          1: lim = LIMIT_RESET;
          2: lim = LIMIT_MAX;
          3: lim = 34'd3;
          default: begin
            span = {$urandom, $urandom};
            span = span % ({30'd0, LIMIT_MAX} - 64'd2) + 64'd3;
            lim = span[LIMIT_W-1:0];
          end
        endcase
        write_limit(lim);
        cfg_sel++;
        next_cfg = bytes_sent + CFG_STEP;
      end
      kind = $urandom_range(0, 99);
      id_len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 40))
                                            : 8'($urandom_range(0, 3));
      w = 16'($urandom_range(1, 6));
      h = 16'($urandom_range(1, 4));
      desc = $urandom_range(0, 1) ? TOP_MASK : 8'h00;
      total = 64'd18 + 64'(id_len) + 64'(w) * 64'(h) * 64'd3;
      if (kind < 55) begin
        run_image(id_len, w, h, desc, 0, 0, ($urandom_range(0, 19) == 0) ? 20 : -1);
      end else if (kind < 68) begin
        run_image(id_len, w, h, desc, $urandom_range(1, 32'(total) - 1), 0, -1);
      end else if (kind < 76) begin
        run_image(id_len, w, h, desc, 0, $urandom_range(1, 4), -1);
      end else if (kind < 90) begin
        run_faulty(4'($urandom_range(ERR_COLORMAPPED, ERR_INTERLEAVE)), $urandom_range(0, 6));
      end else if (kind < 95) begin
        run_image(id_len, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  desc, 64'd18 + 64'(id_len) + 64'($urandom_range(1, 12)), 0, -1);
      end else begin
        stream_q.delete();
        repeat ($urandom_range(1, 40)) stream_q.push_back(8'($urandom_range(0, 255)));
        send_stream(-1);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (decode_sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
